// ===== src/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/wso_pkg.sv =====
package wso_pkg;

    localparam int TABLE_LEN_DEF   = 2048;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int STEP_BITS = 32;
    localparam int GAIN_BITS = 32;
    localparam int PROD_BITS = STEP_BITS + GAIN_BITS;
    localparam int PROD_TOP  = 47;
    localparam int FRAC_BITS = 16;

    localparam logic [GAIN_BITS-1:0] FREQ_GAIN_RESET = 32'h0001_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int BACK_STAGES = 3;
    localparam int IN_FLIGHT_MAX = 1 + QUEUE_DEPTH + BACK_STAGES;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam int TAYLOR_TERMS = 7;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/wavetable_sine_oscillator.sv =====
// Wavetable sine oscillator: every input word carries a phase step (Q0.32 turns) and a restart
// flag, and yields exactly one output word, the sine at the current phase, linearly
// interpolated between two neighboring entries of a TABLE_LEN-entry ROM (TABLE_LEN a power of
// two) and given as a signed Q1.15 value. Restart clears the phase before the sample is taken;
// afterwards the phase advances by phase_step times freq_gain (Q16.16), wrapping modulo one
// turn. A word is accepted every clock cycle while the output side keeps up; that rate is set
// by the phase accumulate loop and by the ROM, which reads both neighbors at once. The gain
// multiply is registered at the accepting edge; from there, when nothing stalls, the output
// word passes through the phase queue write, the ROM read, the interpolation multiply and the
// output register. A four-word phase queue between the phase front end and the interpolator
// lets either side stall on its own. freq_gain resets to 1.0 and should only be written while
// no words are in flight.
module wavetable_sine_oscillator #(
    parameter int TABLE_LEN   = wso_pkg::TABLE_LEN_DEF,
    parameter int PHASE_BITS  = wso_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = wso_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          freq_gain_we,
    input  logic [wso_pkg::GAIN_BITS-1:0] freq_gain_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wso_pkg::STEP_BITS-1:0] s_tdata,   // phase_step
    input  logic                          s_tuser,   // restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_BITS-1:0]         m_tdata    // amplitude, zero fill above
);

    wso_pkg::queue_status_t queue_status;
    logic                   push;
    logic [PHASE_BITS-1:0]  push_phase;
    logic                   pop;
    logic [PHASE_BITS-1:0]  pop_phase;
    logic [SAMPLE_BITS-1:0] amplitude;

    wso_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .freq_gain_we    (freq_gain_we),
        .freq_gain_wdata (freq_gain_wdata),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .phase_step      (s_tdata),
        .restart         (s_tuser),
        .queue_status    (queue_status),
        .push            (push),
        .push_phase      (push_phase)
    );

    wso_queue #(
        .PHASE_BITS (PHASE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_phase),
        .pop       (pop),
        .pop_data  (pop_phase),
        .status    (queue_status)
    );

    wso_back #(
        .TABLE_LEN   (TABLE_LEN),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .pop_phase    (pop_phase),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .amplitude    (amplitude)
    );

    assign m_tdata = TDATA_BITS'(amplitude);

endmodule

// ===== src/wso_front.sv =====
module wso_front #(
    parameter int PHASE_BITS = wso_pkg::PHASE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           freq_gain_we,
    input  logic [wso_pkg::GAIN_BITS-1:0]  freq_gain_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wso_pkg::STEP_BITS-1:0]  phase_step,
    input  logic                           restart,
    input  wso_pkg::queue_status_t         queue_status,
    output logic                           push,
    output logic [PHASE_BITS-1:0]          push_phase
);

    logic [wso_pkg::GAIN_BITS-1:0] freq_gain_reg;
    logic                          valid_reg;
    logic [PHASE_BITS-1:0]         inc_reg;
    logic                          restart_reg;
    logic [PHASE_BITS-1:0]         acc_reg;
    logic [PHASE_BITS-1:0]         acc_next;
    logic [wso_pkg::PROD_BITS-1:0] prod;

    assign prod       = wso_pkg::PROD_BITS'(phase_step) * wso_pkg::PROD_BITS'(freq_gain_reg);
    assign in_ready   = !valid_reg || !queue_status.full;
    assign push       = valid_reg && !queue_status.full;
    assign push_phase = restart_reg ? '0 : acc_reg;
    assign acc_next   = push_phase + inc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_gain_reg <= wso_pkg::FREQ_GAIN_RESET;
            valid_reg     <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (freq_gain_we)
            begin
                freq_gain_reg <= freq_gain_wdata;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (push)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // truncated scaled increment, modulo one turn
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            inc_reg     <= prod[wso_pkg::PROD_TOP -: PHASE_BITS];
            restart_reg <= restart;
        end
    end

endmodule

// ===== src/wso_queue.sv =====
module wso_queue #(
    parameter int PHASE_BITS = wso_pkg::PHASE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [PHASE_BITS-1:0]  push_data,
    input  logic                   pop,
    output logic [PHASE_BITS-1:0]  pop_data,
    output wso_pkg::queue_status_t status
);

    localparam int PTR_BITS = $clog2(wso_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(wso_pkg::QUEUE_DEPTH + 1);

    logic [PHASE_BITS-1:0] entry_reg [wso_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    assign status.full  = count_reg == CNT_BITS'(wso_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/wso_back.sv =====
module wso_back #(
    parameter int TABLE_LEN   = wso_pkg::TABLE_LEN_DEF,
    parameter int PHASE_BITS  = wso_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = wso_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wso_pkg::queue_status_t queue_status,
    input  logic [PHASE_BITS-1:0]  pop_phase,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] amplitude
);

    localparam int IDX_BITS = $clog2(TABLE_LEN);
    localparam int FB       = wso_pkg::FRAC_BITS;
    localparam int WGT_BITS = FB + 1;
    localparam int P0_BITS  = SAMPLE_BITS + WGT_BITS;
    localparam int SUM_BITS = P0_BITS + 1;
    localparam longint signed SAMPLE_PEAK = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    typedef logic [SAMPLE_BITS-1:0] rom_t [TABLE_LEN];

    function automatic longint unsigned quarter_sine(longint unsigned num);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint signed   sum;
        x   = (num * wso_pkg::HALF_PI_Q30 + TABLE_LEN / 2) / TABLE_LEN;
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        for (int k = 0; k < wso_pkg::TAYLOR_TERMS; k++)
        begin
            mag = ((mag * x2) >> 30) / wso_pkg::TAYLOR_DIV[k];
            if ((k % 2) == 0)
            begin
                sum = sum - longint'(mag);
            end
            else
            begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (longint'(wso_pkg::ONE_Q30) < sum)
        begin
            sum = longint'(wso_pkg::ONE_Q30);
        end
        return longint'(sum);
    endfunction

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned m;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned num;
        longint unsigned s;
        longint signed   v;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            m    = 64'd4 * longint'(i);
            quad = m / TABLE_LEN;
            rem  = m % TABLE_LEN;
            num  = quad[0] ? (TABLE_LEN - rem) : rem;
            s    = quarter_sine(num);
            v    = longint'((s * SAMPLE_PEAK + (wso_pkg::ONE_Q30 >> 1)) >> 30);
            if (quad >= 2)
            begin
                v = -v;
            end
            rom[i] = SAMPLE_BITS'(v);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic                   ready_a;
    logic                   ready_b;
    logic                   ready_c;
    logic [IDX_BITS-1:0]    idx;
    logic [IDX_BITS-1:0]    nxt;
    logic [PHASE_BITS-1:0]  pos_low;
    logic                   va_reg;
    logic [SAMPLE_BITS-1:0] rom0_reg;
    logic [SAMPLE_BITS-1:0] rom1_reg;
    logic [FB-1:0]          frac_reg;
    logic [SAMPLE_BITS-1:0] u0;
    logic [SAMPLE_BITS-1:0] u1;
    logic [WGT_BITS-1:0]    wgt0;
    logic                   vb_reg;
    logic [P0_BITS-1:0]     prod0_reg;
    logic [P0_BITS-1:0]     prod1_reg;
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] mix;
    logic                   vc_reg;
    logic [SAMPLE_BITS-1:0] amp_reg;

    assign ready_c = !vc_reg || out_ready;
    assign ready_b = !vb_reg || ready_c;
    assign ready_a = !va_reg || ready_b;
    assign pop     = ready_a && !queue_status.empty;

    // table position: index and fraction, neighbor wraps to entry zero
    assign idx     = pop_phase[PHASE_BITS-1 -: IDX_BITS];
    assign nxt     = idx + 1'b1;
    assign pos_low = pop_phase << IDX_BITS;

    // offset binary: flip the sign bit
    assign u0   = {~rom0_reg[SAMPLE_BITS-1], rom0_reg[SAMPLE_BITS-2:0]};
    assign u1   = {~rom1_reg[SAMPLE_BITS-1], rom1_reg[SAMPLE_BITS-2:0]};
    assign wgt0 = (WGT_BITS'(1) << FB) - WGT_BITS'(frac_reg);

    assign sum = SUM_BITS'(prod0_reg) + SUM_BITS'(prod1_reg) + (SUM_BITS'(1) << (FB - 1));
    assign mix = sum[FB +: SAMPLE_BITS];

    assign out_valid = vc_reg;
    assign amplitude = amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= !queue_status.empty;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rom0_reg <= SINE_ROM[idx];
            rom1_reg <= SINE_ROM[nxt];
            frac_reg <= pos_low[PHASE_BITS-1 -: FB];
        end
        if (ready_b && va_reg)
        begin
            prod0_reg <= P0_BITS'(u0) * P0_BITS'(wgt0);
            prod1_reg <= P0_BITS'(u1) * P0_BITS'(frac_reg);
        end
        if (ready_c && vb_reg)
        begin
            amp_reg <= {~mix[SAMPLE_BITS-1], mix[SAMPLE_BITS-2:0]};
        end
    end

endmodule

// ===== src/wso_checker.sv =====
`include "assert_macros.svh"

module wso_checker #(
    parameter int SAMPLE_BITS = wso_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_BITS  = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata
);

    localparam int CNT_BITS = $clog2(wso_pkg::IN_FLIGHT_MAX + 2);
    localparam logic [CNT_BITS-1:0] CAP = CNT_BITS'(wso_pkg::IN_FLIGHT_MAX);
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                in_acc;
    logic                out_acc;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);

    // words accepted and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, m_tvalid, cnt_reg != '0)
    `ASSERT_IMPLIES(a_capacity, clk, rst_n, in_acc, cnt_reg < CAP)
    `ASSERT_IMPLIES(a_sample_range, clk, rst_n, m_tvalid, m_tdata[SAMPLE_BITS-1:0] != MOST_NEG)

endmodule

bind wavetable_sine_oscillator wso_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TDATA_BITS  (TDATA_BITS)
) u_wso_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
